### hw/rtl/ptm_pkg.sv
// shared constants for the page table map/unmap engine
// status codes, op codes, entry flag positions and default sizes
// no dependencies
`default_nettype none

package ptm_pkg;

    localparam int DEF_TABLE_COUNT    = 64;
    localparam int DEF_IDENTITY_GIB   = 4;
    localparam int DEF_HIGH_ALIAS_GIB = 2;

    localparam int ENTRIES = 512;
    localparam int IDX_W   = 9;
    localparam int PA_W    = 52;
    localparam int VA_W    = 48;
    localparam int PFN_W   = 40;
    localparam int ENTRY_W = 64;

    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_UNMAP = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_MAPPED = 3'd1;
    localparam logic [2:0] ST_NOINIT = 3'd2;
    localparam logic [2:0] ST_NOTAB  = 3'd3;
    localparam logic [2:0] ST_NOMAP  = 3'd4;

    localparam int F_P = 0;
    localparam int F_W = 1;
    localparam int F_L = 7;

endpackage

`default_nettype wire

### hw/rtl/page_table_map_unmap_engine.sv
// top level of the four-level page table engine: pool base register,
// sequencer and table pool; depends on ptm_pkg, ptm_engine, ptm_ram
//
// usage: one command transfer when start is high and busy is low, carrying
// op (0 map, 1 unmap, 2 build identity map), virt_addr, frame_addr, writable.
// busy stays high until the command completes; the result (status,
// flush_valid, flush_page, root_addr) is shown for exactly one cycle with
// done high, and busy is already low in that cycle, so the next command may
// be given at once. the receiver cannot stall results.
// pool_base is written with cfg_we/cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce it.
// an unused op, or a check that fails before a walk, ends the command without
// a walk. each walk level reads the pool through its registered read port,
// and every table created or 2 MiB page split is swept by the single write
// port, which clears or fills one entry a cycle.
// identity build: three tables are cleared, then per GiB the links are written
// and a 2 MiB page directory is filled.
// reset empties the pool count and clears the root; pool contents are not
// cleared, since every table is cleared or filled when it is handed out.
`default_nettype none

module page_table_map_unmap_engine #(
    parameter int TABLE_COUNT    = ptm_pkg::DEF_TABLE_COUNT,
    parameter int IDENTITY_GIB   = ptm_pkg::DEF_IDENTITY_GIB,
    parameter int HIGH_ALIAS_GIB = ptm_pkg::DEF_HIGH_ALIAS_GIB
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [51:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [47:0] virt_addr,
    input  wire logic [51:0] frame_addr,
    input  wire logic        writable,
    output logic             done,
    output logic [2:0]       status,
    output logic             flush_valid,
    output logic [35:0]      flush_page,
    output logic [51:0]      root_addr
);

    localparam int TW = $clog2(TABLE_COUNT);
    localparam int AW = TW + ptm_pkg::IDX_W;

    logic [51:0] pool_base_reg;
    logic [51:0] pool_base_next;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [AW-1:0]               mem_raddr;
    logic [ptm_pkg::ENTRY_W-1:0] mem_wdata;
    logic [ptm_pkg::ENTRY_W-1:0] mem_rdata;

    assign pool_base_next = cfg_we ? cfg_data : pool_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= 52'h0_0000_0010_0000;
        end
        else
        begin
            pool_base_reg <= pool_base_next;
        end
    end

    ptm_engine #(
        .TABLE_COUNT   (TABLE_COUNT),
        .IDENTITY_GIB  (IDENTITY_GIB),
        .HIGH_ALIAS_GIB(HIGH_ALIAS_GIB),
        .TW            (TW),
        .AW            (AW)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .virt_addr  (virt_addr),
        .frame_addr (frame_addr),
        .writable   (writable),
        .pool_pfn   (pool_base_reg[51:12]),
        .done       (done),
        .status     (status),
        .flush_valid(flush_valid),
        .flush_page (flush_page),
        .root_addr  (root_addr),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    ptm_ram #(
        .AW(AW),
        .DW(ptm_pkg::ENTRY_W)
    ) u_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

endmodule

`default_nettype wire

### hw/rtl/ptm_ram.sv
// table pool storage: one write port, one registered read port
// depends on nothing
`default_nettype none

module ptm_ram #(
    parameter int AW = 15,
    parameter int DW = 64
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/ptm_engine.sv
// sequencer for map, unmap and identity-map build over the table pool
// depends on ptm_pkg, drives the ptm_ram ports
`default_nettype none

module ptm_engine #(
    parameter int TABLE_COUNT    = ptm_pkg::DEF_TABLE_COUNT,
    parameter int IDENTITY_GIB   = ptm_pkg::DEF_IDENTITY_GIB,
    parameter int HIGH_ALIAS_GIB = ptm_pkg::DEF_HIGH_ALIAS_GIB,
    parameter int TW = $clog2(TABLE_COUNT),
    parameter int AW = TW + ptm_pkg::IDX_W
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  op,
    input  wire logic [ptm_pkg::VA_W-1:0]    virt_addr,
    input  wire logic [ptm_pkg::PA_W-1:0]    frame_addr,
    input  wire logic                        writable,
    input  wire logic [ptm_pkg::PFN_W-1:0]   pool_pfn,
    output logic                             done,
    output logic [2:0]                       status,
    output logic                             flush_valid,
    output logic [35:0]                      flush_page,
    output logic [ptm_pkg::PA_W-1:0]         root_addr,
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output logic [ptm_pkg::ENTRY_W-1:0]      mem_wdata,
    output logic [AW-1:0]                    mem_raddr,
    input  wire logic [ptm_pkg::ENTRY_W-1:0] mem_rdata
);

    localparam int CW = $clog2(TABLE_COUNT + 1);
    localparam int GW = $clog2(IDENTITY_GIB + 1);
    localparam int IW = ptm_pkg::IDX_W;
    localparam int EW = ptm_pkg::ENTRY_W;
    localparam logic [CW-1:0] TC_C = CW'(TABLE_COUNT);
    localparam logic [CW-1:0] NEED = CW'(3 + IDENTITY_GIB);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_INIT  = 3'd4;

    localparam logic [1:0] M_ZERO  = 2'd0;
    localparam logic [1:0] M_SPLIT = 2'd1;
    localparam logic [1:0] M_PD    = 2'd2;

    localparam logic [EW-1:0] FL_PW  = EW'(3);
    localparam logic [EW-1:0] FL_PWL = EW'(8'h83);

    logic [2:0]            state_reg, state_next;
    logic [2:0]            ret_reg, ret_next;
    logic [1:0]            mode_reg, mode_next;
    logic [1:0]            op_reg, op_next;
    logic [ptm_pkg::VA_W-1:0] va_reg, va_next;
    logic [ptm_pkg::PA_W-1:0] pa_reg, pa_next;
    logic                  wr_reg, wr_next;
    logic [1:0]            lvl_reg, lvl_next;
    logic [TW-1:0]         t_reg, t_next;
    logic [CW-1:0]         nf_reg, nf_next;
    logic [ptm_pkg::PA_W-1:0] root_reg, root_next;
    logic [IW-1:0]         cnt_reg, cnt_next;
    logic [30:0]           fill_reg, fill_next;
    logic                  fl_reg, fl_next;
    logic [CW-1:0]         b_reg, b_next;
    logic [GW-1:0]         g_reg, g_next;
    logic [3:0]            ist_reg, ist_next;

    logic                  done_reg, done_next;
    logic [2:0]            status_reg, status_next;
    logic                  fv_reg, fv_next;
    logic [35:0]           fp_reg, fp_next;
    logic [ptm_pkg::PA_W-1:0] ro_reg, ro_next;

    logic [IW-1:0]         idx;
    logic [CW-1:0]         link_tbl;
    logic [ptm_pkg::PA_W-1:0] link_val;
    logic [ptm_pkg::PFN_W-1:0] res_in, res_off;
    logic                  res_ok;
    logic                  is_map;
    logic                  fin, fin_flush;
    logic [2:0]            fin_st;
    logic [EW-1:0]         e;

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign flush_valid = fv_reg;
    assign flush_page  = fp_reg;
    assign root_addr   = ro_reg;
    assign e           = mem_rdata;
    assign is_map      = (op_reg == ptm_pkg::OP_MAP);

    always_comb
    begin
        case (lvl_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    // shared address unit: pointer to pool index, and pool index to table address
    assign res_in   = (state_reg == S_IDLE) ? root_reg[51:12] : e[51:12];
    assign res_off  = res_in - pool_pfn;
    assign res_ok   = (res_off < ptm_pkg::PFN_W'(nf_reg));
    assign link_val = {pool_pfn + ptm_pkg::PFN_W'(link_tbl), 12'h000};

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        mode_next   = mode_reg;
        op_next     = op_reg;
        va_next     = va_reg;
        pa_next     = pa_reg;
        wr_next     = wr_reg;
        lvl_next    = lvl_reg;
        t_next      = t_reg;
        nf_next     = nf_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        fill_next   = fill_reg;
        fl_next     = fl_reg;
        b_next      = b_reg;
        g_next      = g_reg;
        ist_next    = ist_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        fv_next     = fv_reg;
        fp_next     = fp_reg;
        ro_next     = ro_reg;
        fin         = 1'b0;
        fin_st      = ptm_pkg::ST_OK;
        fin_flush   = 1'b0;
        link_tbl    = nf_reg;
        mem_we      = 1'b0;
        mem_waddr   = {t_reg, idx};
        mem_wdata   = '0;
        mem_raddr   = {t_reg, idx};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = op;
                    va_next = virt_addr;
                    pa_next = frame_addr;
                    wr_next = writable;
                    case (op)
                        ptm_pkg::OP_MAP, ptm_pkg::OP_UNMAP:
                        begin
                            if (root_reg == '0)
                            begin
                                fin    = 1'b1;
                                fin_st = ptm_pkg::ST_NOINIT;
                            end
                            else if (!res_ok)
                            begin
                                fin    = 1'b1;
                                fin_st = ptm_pkg::ST_NOMAP;
                            end
                            else
                            begin
                                t_next     = res_off[TW-1:0];
                                lvl_next   = 2'd0;
                                state_next = S_RD;
                            end
                        end
                        ptm_pkg::OP_INIT:
                        begin
                            if ((TC_C - nf_reg) < NEED)
                            begin
                                fin    = 1'b1;
                                fin_st = ptm_pkg::ST_NOTAB;
                            end
                            else
                            begin
                                b_next     = nf_reg;
                                g_next     = '0;
                                ist_next   = 4'd0;
                                state_next = S_INIT;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (lvl_reg == 2'd3)
                begin
                    fin = 1'b1;
                    if (is_map)
                    begin
                        if (e[ptm_pkg::F_P])
                        begin
                            fin_st = ptm_pkg::ST_MAPPED;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {12'h000, pa_reg[51:12], 12'h000}
                                        | EW'(1) | (EW'(wr_reg) << ptm_pkg::F_W);
                            fin_flush = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!e[ptm_pkg::F_P])
                        begin
                            fin_st = ptm_pkg::ST_NOMAP;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '0;
                            fin_flush = 1'b1;
                        end
                    end
                end
                else if (e[ptm_pkg::F_P] && (lvl_reg == 2'd2) && e[ptm_pkg::F_L])
                begin
                    // 2 MiB page: replace by a table of 4 KiB pages
                    if (nf_reg >= TC_C)
                    begin
                        fin    = 1'b1;
                        fin_st = ptm_pkg::ST_NOTAB;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = {12'h000, link_val} | EW'(1)
                                     | (EW'(e[ptm_pkg::F_W]) << ptm_pkg::F_W);
                        fill_next  = e[51:21];
                        fl_next    = e[ptm_pkg::F_W];
                        t_next     = nf_reg[TW-1:0];
                        nf_next    = nf_reg + CW'(1);
                        lvl_next   = 2'd3;
                        cnt_next   = '0;
                        mode_next  = M_SPLIT;
                        ret_next   = S_RD;
                        state_next = S_SWEEP;
                    end
                end
                else if (e[ptm_pkg::F_P])
                begin
                    if (res_ok)
                    begin
                        t_next     = res_off[TW-1:0];
                        lvl_next   = lvl_reg + 2'd1;
                        state_next = S_RD;
                    end
                    else
                    begin
                        fin    = 1'b1;
                        fin_st = ptm_pkg::ST_NOMAP;
                    end
                end
                else if (!is_map)
                begin
                    fin    = 1'b1;
                    fin_st = ptm_pkg::ST_NOMAP;
                end
                else if (nf_reg >= TC_C)
                begin
                    fin    = 1'b1;
                    fin_st = ptm_pkg::ST_NOTAB;
                end
                else
                begin
                    // link a fresh table, then clear it
                    mem_we     = 1'b1;
                    mem_wdata  = {12'h000, link_val} | FL_PW;
                    t_next     = nf_reg[TW-1:0];
                    nf_next    = nf_reg + CW'(1);
                    lvl_next   = lvl_reg + 2'd1;
                    cnt_next   = '0;
                    mode_next  = M_ZERO;
                    ret_next   = S_RD;
                    state_next = S_SWEEP;
                end
            end

            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = {t_reg, cnt_reg};
                case (mode_reg)
                    M_SPLIT:
                    begin
                        mem_wdata = {12'h000, fill_reg, cnt_reg, 12'h000} | EW'(1)
                                    | (EW'(fl_reg) << ptm_pkg::F_W);
                    end
                    M_PD:
                    begin
                        mem_wdata = (EW'(g_reg) << 30) | (EW'(cnt_reg) << 21) | FL_PWL;
                    end
                    default:
                    begin
                        mem_wdata = '0;
                    end
                endcase
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == IW'(ptm_pkg::ENTRIES - 1))
                begin
                    state_next = ret_reg;
                end
            end

            S_INIT:
            begin
                case (ist_reg)
                    4'd0, 4'd1, 4'd2:
                    begin
                        link_tbl   = b_reg + CW'(ist_reg);
                        t_next     = link_tbl[TW-1:0];
                        cnt_next   = '0;
                        mode_next  = M_ZERO;
                        ret_next   = S_INIT;
                        ist_next   = ist_reg + 4'd1;
                        state_next = S_SWEEP;
                    end
                    4'd3:
                    begin
                        link_tbl  = b_reg + CW'(1);
                        mem_we    = 1'b1;
                        mem_waddr = {b_reg[TW-1:0], IW'(0)};
                        mem_wdata = {12'h000, link_val} | FL_PW;
                        ist_next  = 4'd4;
                    end
                    4'd4:
                    begin
                        link_tbl  = b_reg + CW'(2);
                        mem_we    = 1'b1;
                        mem_waddr = {b_reg[TW-1:0], IW'(511)};
                        mem_wdata = {12'h000, link_val} | FL_PW;
                        ist_next  = 4'd5;
                    end
                    4'd5:
                    begin
                        link_tbl  = b_reg + CW'(3) + CW'(g_reg);
                        t_next    = b_reg[TW-1:0] + TW'(1);
                        mem_we    = 1'b1;
                        mem_waddr = {t_next, IW'(g_reg)};
                        mem_wdata = {12'h000, link_val} | FL_PW;
                        ist_next  = 4'd6;
                    end
                    4'd6:
                    begin
                        link_tbl  = b_reg + CW'(3) + CW'(g_reg);
                        t_next    = b_reg[TW-1:0] + TW'(2);
                        mem_we    = (32'(g_reg) < HIGH_ALIAS_GIB);
                        mem_waddr = {t_next, IW'(510) + IW'(g_reg)};
                        mem_wdata = {12'h000, link_val} | FL_PW;
                        ist_next  = 4'd7;
                    end
                    4'd7:
                    begin
                        link_tbl   = b_reg + CW'(3) + CW'(g_reg);
                        t_next     = link_tbl[TW-1:0];
                        cnt_next   = '0;
                        mode_next  = M_PD;
                        ret_next   = S_INIT;
                        ist_next   = 4'd8;
                        state_next = S_SWEEP;
                    end
                    default:
                    begin
                        link_tbl = b_reg;
                        if (g_reg == GW'(IDENTITY_GIB - 1))
                        begin
                            nf_next   = b_reg + NEED;
                            root_next = link_val;
                            fin       = 1'b1;
                        end
                        else
                        begin
                            g_next   = g_reg + GW'(1);
                            ist_next = 4'd5;
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            status_next = fin_st;
            fv_next     = fin_flush;
            fp_next     = fin_flush ? va_next[47:12] : 36'h0;
            ro_next     = root_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nf_reg    <= '0;
            root_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nf_reg    <= nf_next;
            root_reg  <= root_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg    <= ret_next;
        mode_reg   <= mode_next;
        op_reg     <= op_next;
        va_reg     <= va_next;
        pa_reg     <= pa_next;
        wr_reg     <= wr_next;
        lvl_reg    <= lvl_next;
        t_reg      <= t_next;
        cnt_reg    <= cnt_next;
        fill_reg   <= fill_next;
        fl_reg     <= fl_next;
        b_reg      <= b_next;
        g_reg      <= g_next;
        ist_reg    <= ist_next;
        status_reg <= status_next;
        fv_reg     <= fv_next;
        fp_reg     <= fp_next;
        ro_reg     <= ro_next;
    end

endmodule

`default_nettype wire

### hw/rtl/ptm_checker.sv
// port-level checks for the page table engine, bound to the top level
// depends on ptm_pkg
`default_nettype none

module ptm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [2:0]  status,
    input wire logic        flush_valid,
    input wire logic [35:0] flush_page
);

    // a completed command is always reported from idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && flush_valid) |-> (status == ptm_pkg::ST_OK))
        else $error("flush with failing status");

    a_no_flush_page: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !flush_valid) |-> (flush_page == 36'h0))
        else $error("flush page set without flush");

    // every accepted command either runs or completes next cycle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("command transfer lost");

endmodule

bind page_table_map_unmap_engine ptm_checker u_ptm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .flush_valid(flush_valid),
    .flush_page (flush_page)
);

`default_nettype wire
